### hdl/ray_triangle_first_hit_top_macros.svh
// Assertion macros used by the checker file.
`ifndef RAY_TRIANGLE_FIRST_HIT_TOP_MACROS_SVH
`define RAY_TRIANGLE_FIRST_HIT_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RTFH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define RTFH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rtfh_pkg.sv
// ----------------------------------------------------------------------------
// rtfh_pkg
// Shared types, constants and fixed-point helpers of the ray/triangle block.
// ----------------------------------------------------------------------------
package rtfh_pkg;

  localparam int CW = 32;
  localparam int FB = 16;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t VMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t VMIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t ONE  = coord_t'(64'd1 << FB);
  localparam coord_t EPS  = coord_t'(((64'd1 << FB) + 64'd5000) / 64'd10000);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  // Datapath operation codes.
  typedef enum logic [1:0] {
    OP_SUB, OP_MUL, OP_ADD, OP_HOLD
  } op_t;

  typedef struct packed {
    logic       load;      // capture triangle, start edge terms
    logic       step;      // advance the micro-program one step
    logic       div_start; // start reciprocal
  } dp_cmd_t;

  typedef struct packed {
    logic       prog_done; // micro-program reached end or rejected
    logic       div_busy;
    logic       need_div;  // program waits on reciprocal
    logic       hit;
  } dp_stat_t;

  // Saturating add/sub.
  function automatic coord_t sadd(coord_t a, coord_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) return s[CW] ? VMIN : VMAX;
    return s[CW-1:0];
  endfunction

  function automatic coord_t ssub(coord_t a, coord_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} - {b[CW-1], b};
    if (s[CW] != s[CW-1]) return s[CW] ? VMIN : VMAX;
    return s[CW-1:0];
  endfunction

  // Product shifted right by FB (floor), saturated.
  function automatic coord_t mul_sat(logic signed [2*CW-1:0] p);
    logic signed [2*CW-1:0] q;
    q = p >>> FB;
    if (q > $signed({{CW{VMAX[CW-1]}}, VMAX})) return VMAX;
    if (q < $signed({{CW{VMIN[CW-1]}}, VMIN})) return VMIN;
    return q[CW-1:0];
  endfunction

endpackage

### hdl/rtfh_stream_if.sv
// ----------------------------------------------------------------------------
// rtfh_tri_if / rtfh_res_if
// Valid/ready channels for triangle beats and result beats.
// ----------------------------------------------------------------------------
interface rtfh_tri_if import rtfh_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
  logic   last_triangle;
  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, last_triangle, input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, last_triangle, output ready);
endinterface

interface rtfh_res_if import rtfh_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t point_x, point_y, point_z;
  modport source (output valid, hit, point_x, point_y, point_z, input ready);
  modport sink   (input valid, hit, point_x, point_y, point_z, output ready);
endinterface

### hdl/ray_triangle_first_hit_top.sv
// ----------------------------------------------------------------------------
// ray_triangle_first_hit_top
// First-hit Moller-Trumbore ray/triangle test in signed Q16.16.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// tri_in   in   v0..v2 xyz, last_triangle
// res_out  out  hit, point_x/y/z
// cfg      in   cfg_we, cfg_idx, cfg_data (origin, dir)
//
// Each triangle runs a micro-program of 48 steps on one shared 32x32 multiplier
// and saturating adder, plus a restoring divider for the reciprocal with a
// handoff around it. A triangle rejected on its determinant frees the input
// before the divider runs; a full hit runs the whole program.
// Triangles after a hit in the same query are accepted and dropped unrun.
// rst is synchronous; it clears the sequencer, hit tracking, ray registers and output valid.
// The result register holds its beat until taken; the next triangle is
// taken meanwhile and stalls only when its own result must go out.
module ray_triangle_first_hit_top import rtfh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  coord_t               cfg_data,
  rtfh_tri_if.sink             tri_in,
  rtfh_res_if.source           res_out
);
  coord_t   org [3];
  coord_t   dir [3];
  coord_t   vin [9];
  coord_t   pt  [3];
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_load, out_hit, out_free;

  // Hold ray registers; writes past the last index drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        REG_DIR_X:    dir[0] <= cfg_data;
        REG_DIR_Y:    dir[1] <= cfg_data;
        REG_DIR_Z:    dir[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vin[0] = tri_in.v0_x;
  assign vin[1] = tri_in.v0_y;
  assign vin[2] = tri_in.v0_z;
  assign vin[3] = tri_in.v1_x;
  assign vin[4] = tri_in.v1_y;
  assign vin[5] = tri_in.v1_z;
  assign vin[6] = tri_in.v2_x;
  assign vin[7] = tri_in.v2_y;
  assign vin[8] = tri_in.v2_z;

  rtfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tri_in.valid),
    .in_last  (tri_in.last_triangle),
    .in_ready (tri_in.ready),
    .cmd      (cmd),
    .stat     (stat),
    .out_free (out_free),
    .out_load (out_load),
    .out_hit  (out_hit)
  );

  rtfh_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .org  (org),
    .dir  (dir),
    .vin  (vin),
    .pt   (pt)
  );

  // Output register: load when empty or being drained; zero point on a miss.
  assign out_free = !res_out.valid || res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (out_load) begin
      res_out.valid <= 1'b1;
    end else if (res_out.ready) begin
      res_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_out.hit     <= out_hit;
      res_out.point_x <= out_hit ? pt[0] : '0;
      res_out.point_y <= out_hit ? pt[1] : '0;
      res_out.point_z <= out_hit ? pt[2] : '0;
    end
  end
endmodule

### hdl/rtfh_recip.sv
// ----------------------------------------------------------------------------
// rtfh_recip
// Restoring divider: 2^(2*FB) / a (sign restored), one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module rtfh_recip import rtfh_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  coord_t a,
  output logic   busy,
  output coord_t f
);
  localparam int NW = 2*FB + 1;            // numerator bits
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num;
  logic [CW:0]      rem;
  logic [CW-1:0]    den;
  logic [NW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [CW+1:0]    trial;
  logic [NW-1:0]    quo_next;

  always_comb begin
    trial    = {rem, num[NW-1]} - {2'b00, den};
    quo_next = {quo[NW-2:0], ~trial[CW+1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NW);
      num  <= NW'(1) << (2*FB);
      rem  <= '0;
      quo  <= '0;
      neg  <= a[CW-1];
      den  <= a[CW-1] ? CW'(-a) : CW'(a);
    end else if (busy) begin
      num <= {num[NW-2:0], 1'b0};
      quo <= quo_next;
      rem <= trial[CW+1] ? {rem[CW-1:0], num[NW-1]} : trial[CW:0];
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_comb begin
    if (!neg) f = (quo > NW'(VMAX)) ? VMAX : CW'(quo);
    else if (quo > NW'(VMAX) + NW'(1)) f = VMIN;
    else f = CW'(-quo);
  end
endmodule

### hdl/rtfh_datapath.sv
// ----------------------------------------------------------------------------
// rtfh_datapath
// Register file, shared multiplier and adder, reciprocal unit; runs one
// micro-program per triangle, one operation per step.
// ----------------------------------------------------------------------------
module rtfh_datapath import rtfh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  coord_t   org [3],
  input  coord_t   dir [3],
  input  coord_t   vin [9],
  output coord_t   pt  [3]
);
  // Register file slots.
  localparam int NR = 32;
  localparam logic [4:0]
    R_O0=0, R_O1=1, R_O2=2, R_D0=3, R_D1=4, R_D2=5,
    R_E10=6, R_E11=7, R_E12=8, R_E20=9, R_E21=10, R_E22=11,
    R_S0=12, R_S1=13, R_S2=14, R_H0=15, R_H1=16, R_H2=17,
    R_Q0=18, R_Q1=19, R_Q2=20, R_T0=21, R_T1=22, R_A=23,
    R_F=24, R_U=25, R_V=26, R_T=27, R_P0=28, R_P1=29, R_P2=30, R_X=31;

  // Checks applied after an op.
  typedef enum logic [2:0] {CK_NONE, CK_A, CK_U, CK_V, CK_T, CK_DIV} ck_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] a, b, d;
    ck_t        ck;
  } uop_t;

  localparam int PC_W = 6;

  function automatic uop_t prog(logic [PC_W-1:0] pc);
    unique case (pc)
      // h = dir x e2
      6'd0:  return '{OP_MUL, R_D1, R_E22, R_T0, CK_NONE};
      6'd1:  return '{OP_MUL, R_D2, R_E21, R_T1, CK_NONE};
      6'd2:  return '{OP_SUB, R_T0, R_T1, R_H0, CK_NONE};
      6'd3:  return '{OP_MUL, R_D2, R_E20, R_T0, CK_NONE};
      6'd4:  return '{OP_MUL, R_D0, R_E22, R_T1, CK_NONE};
      6'd5:  return '{OP_SUB, R_T0, R_T1, R_H1, CK_NONE};
      6'd6:  return '{OP_MUL, R_D0, R_E21, R_T0, CK_NONE};
      6'd7:  return '{OP_MUL, R_D1, R_E20, R_T1, CK_NONE};
      6'd8:  return '{OP_SUB, R_T0, R_T1, R_H2, CK_NONE};
      // a = e1 . h
      6'd9:  return '{OP_MUL, R_E10, R_H0, R_A, CK_NONE};
      6'd10: return '{OP_MUL, R_E11, R_H1, R_T0, CK_NONE};
      6'd11: return '{OP_ADD, R_A, R_T0, R_A, CK_NONE};
      6'd12: return '{OP_MUL, R_E12, R_H2, R_T0, CK_NONE};
      6'd13: return '{OP_ADD, R_A, R_T0, R_A, CK_A};
      6'd14: return '{OP_HOLD, R_A, R_A, R_X, CK_DIV};
      // u = f * (s . h)
      6'd15: return '{OP_MUL, R_S0, R_H0, R_U, CK_NONE};
      6'd16: return '{OP_MUL, R_S1, R_H1, R_T0, CK_NONE};
      6'd17: return '{OP_ADD, R_U, R_T0, R_U, CK_NONE};
      6'd18: return '{OP_MUL, R_S2, R_H2, R_T0, CK_NONE};
      6'd19: return '{OP_ADD, R_U, R_T0, R_U, CK_NONE};
      6'd20: return '{OP_MUL, R_F, R_U, R_U, CK_U};
      // q = s x e1
      6'd21: return '{OP_MUL, R_S1, R_E12, R_T0, CK_NONE};
      6'd22: return '{OP_MUL, R_S2, R_E11, R_T1, CK_NONE};
      6'd23: return '{OP_SUB, R_T0, R_T1, R_Q0, CK_NONE};
      6'd24: return '{OP_MUL, R_S2, R_E10, R_T0, CK_NONE};
      6'd25: return '{OP_MUL, R_S0, R_E12, R_T1, CK_NONE};
      6'd26: return '{OP_SUB, R_T0, R_T1, R_Q1, CK_NONE};
      6'd27: return '{OP_MUL, R_S0, R_E11, R_T0, CK_NONE};
      6'd28: return '{OP_MUL, R_S1, R_E10, R_T1, CK_NONE};
      6'd29: return '{OP_SUB, R_T0, R_T1, R_Q2, CK_NONE};
      // v = f * (dir . q)
      6'd30: return '{OP_MUL, R_D0, R_Q0, R_V, CK_NONE};
      6'd31: return '{OP_MUL, R_D1, R_Q1, R_T0, CK_NONE};
      6'd32: return '{OP_ADD, R_V, R_T0, R_V, CK_NONE};
      6'd33: return '{OP_MUL, R_D2, R_Q2, R_T0, CK_NONE};
      6'd34: return '{OP_ADD, R_V, R_T0, R_V, CK_NONE};
      6'd35: return '{OP_MUL, R_F, R_V, R_V, CK_V};
      // t = f * (e2 . q)
      6'd36: return '{OP_MUL, R_E20, R_Q0, R_T, CK_NONE};
      6'd37: return '{OP_MUL, R_E21, R_Q1, R_T0, CK_NONE};
      6'd38: return '{OP_ADD, R_T, R_T0, R_T, CK_NONE};
      6'd39: return '{OP_MUL, R_E22, R_Q2, R_T0, CK_NONE};
      6'd40: return '{OP_ADD, R_T, R_T0, R_T, CK_NONE};
      6'd41: return '{OP_MUL, R_F, R_T, R_T, CK_T};
      // point = org + dir * t
      6'd42: return '{OP_MUL, R_D0, R_T, R_T0, CK_NONE};
      6'd43: return '{OP_ADD, R_O0, R_T0, R_P0, CK_NONE};
      6'd44: return '{OP_MUL, R_D1, R_T, R_T0, CK_NONE};
      6'd45: return '{OP_ADD, R_O1, R_T0, R_P1, CK_NONE};
      6'd46: return '{OP_MUL, R_D2, R_T, R_T0, CK_NONE};
      6'd47: return '{OP_ADD, R_O2, R_T0, R_P2, CK_NONE};
      default: return '{OP_HOLD, R_X, R_X, R_X, CK_NONE};
    endcase
  endfunction

  localparam logic [PC_W-1:0] PC_END = 6'd48;

  coord_t              rf [NR];
  logic [PC_W-1:0]     pc;
  logic                done, hit, wait_div;
  uop_t                u;
  coord_t              ra, rb, res;
  logic signed [2*CW-1:0] prod;
  coord_t              div_f;
  logic                div_busy;
  logic                reject;

  assign u    = prog(pc);
  assign ra   = rf[u.a];
  assign rb   = rf[u.b];
  assign prod = ra * rb;

  always_comb begin
    unique case (u.op)
      OP_SUB:  res = ssub(ra, rb);
      OP_MUL:  res = mul_sat(prod);
      OP_ADD:  res = sadd(ra, rb);
      OP_HOLD: res = ra;
    endcase
  end

  always_comb begin
    reject = 1'b0;
    unique case (u.ck)
      CK_A:    reject = (res == '0) || (res > -EPS && res < EPS);
      CK_U:    reject = (res < 0) || (res > ONE);
      CK_V:    reject = (res < 0) || (sadd(rf[R_U], res) > ONE);
      CK_T:    reject = (res <= EPS);
      CK_NONE: reject = 1'b0;
      CK_DIV:  reject = 1'b0;
      default: reject = 1'b0;
    endcase
  end

  rtfh_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .a     (rf[R_A]),
    .busy  (div_busy),
    .f     (div_f)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      done     <= 1'b1;
      hit      <= 1'b0;
      wait_div <= 1'b0;
    end else if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        rf[R_O0 + 5'(i)]  <= org[i];
        rf[R_D0 + 5'(i)]  <= dir[i];
        rf[R_E10 + 5'(i)] <= ssub(vin[3+i], vin[i]);
        rf[R_E20 + 5'(i)] <= ssub(vin[6+i], vin[i]);
        rf[R_S0 + 5'(i)]  <= ssub(org[i], vin[i]);
      end
      pc       <= '0;
      done     <= 1'b0;
      hit      <= 1'b0;
      wait_div <= 1'b0;
    end else if (wait_div) begin
      if (!div_busy && !cmd.div_start) begin
        rf[R_F]  <= div_f;
        wait_div <= 1'b0;
        pc       <= pc + 1'b1;
      end
    end else if (cmd.step && !done) begin
      rf[u.d] <= res;
      if (reject) begin
        done <= 1'b1;
      end else if (u.ck == CK_DIV) begin
        wait_div <= 1'b1;
      end else if (pc == PC_END - 1'b1) begin
        done <= 1'b1;
        hit  <= 1'b1;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  assign stat.prog_done = done;
  assign stat.div_busy  = div_busy;
  assign stat.need_div  = wait_div;
  assign stat.hit       = hit;
  assign pt[0] = rf[R_P0];
  assign pt[1] = rf[R_P1];
  assign pt[2] = rf[R_P2];
endmodule

### hdl/rtfh_ctrl.sv
// ----------------------------------------------------------------------------
// rtfh_ctrl
// Sequences one triangle: accept, run datapath, post result on a hit or last triangle, track hit_seen.
// ----------------------------------------------------------------------------
module rtfh_ctrl import rtfh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat,
  input  logic     out_free,
  output logic     out_load,
  output logic     out_hit
);
  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_DIV = 2'd2, S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic       hit_seen, last;
  logic       acc;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.step      = 1'b0;
    cmd.div_start = 1'b0;
    out_load      = 1'b0;
    out_hit       = stat.hit;
    unique case (state)
      S_IDLE: if (acc && !hit_seen) begin
        cmd.load   = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (stat.prog_done) begin
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DIV: if (!stat.need_div) state_next = S_RUN;
      S_DONE: begin
        if (!stat.hit && !last) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      hit_seen <= 1'b0;
      last     <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        last <= in_last;
        if (hit_seen && in_last) hit_seen <= 1'b0;
      end
      if (out_load && stat.hit) hit_seen <= !last;
    end
  end
endmodule

### hdl/rtfh_checker.sv
// ----------------------------------------------------------------------------
// rtfh_checker
// Port-level checks of the ray/triangle block.
// ----------------------------------------------------------------------------
`include "ray_triangle_first_hit_top_macros.svh"

module rtfh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [31:0] out_px
);
  `RTFH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "beat dropped")
  `RTFH_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && !out_hit, out_px == 32'd0, "miss point")
  `RTFH_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_px), "beat moved")
  `RTFH_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !out_valid, "result valid after reset")
endmodule

bind ray_triangle_first_hit_top rtfh_checker u_rtfh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (tri_in.valid),
  .in_ready  (tri_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_hit   (res_out.hit),
  .out_px    (res_out.point_x)
);
